// ===== src/aes_pkg.sv =====
package aes_pkg;

  localparam int unsigned NumEvents = 5;
  localparam int unsigned NumRcv    = 8;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_ASSERT  = 3'd1;
  localparam logic [2:0] EV_NEGATE  = 3'd2;
  localparam logic [2:0] EV_CONFIRM = 3'd3;
  localparam logic [2:0] EV_DISABLE = 3'd4;
  localparam logic [2:0] EV_ENABLE  = 3'd5;

  // status word bit positions
  localparam int unsigned StActive    = 0;
  localparam int unsigned StConfirmed = 1;
  localparam int unsigned StDisabled  = 2;
  localparam int unsigned StClassLsb  = 3;

  // flag and sent mask order
  localparam int unsigned FlAssert  = 0;
  localparam int unsigned FlNegate  = 1;
  localparam int unsigned FlConfirm = 2;
  localparam int unsigned FlDisable = 3;
  localparam int unsigned FlEnable  = 4;

  typedef struct packed {
    logic [3:0]                          alarm_class;
    logic [31:0]                         enable_time;
    logic [31:0]                         disable_time;
    logic [31:0]                         confirm_time;
    logic [31:0]                         off_time;
    logic [31:0]                         init_time;
    logic [NumEvents-1:0][NumRcv-1:0]    sent_masks;
    logic [NumRcv-1:0]                   send_mask;
    logic [NumEvents-1:0]                send_flags;
    logic [2:0]                          pc_index;
  } aes_in_t;

  typedef struct packed {
    logic [6:0]  status_word;
    logic [31:0] event_time;
    logic [2:0]  event_kind;
  } aes_out_t;

endpackage

// ===== src/aes_decide.sv =====
module aes_decide import aes_pkg::*; (
  input  aes_in_t  word_i,
  output aes_out_t res_o
);

  logic [NumEvents-1:0] pend;
  logic [3:0]           set;
  logic [2:0]           kind;
  logic [31:0]          off, conf, dis, en;
  logic                 c_ge_o, d_ge_o, e_ge_o, o_ge_d, c_ge_d, d_ge_c;
  logic                 e_ge_c, d_ge_e, e_ge_d;
  logic [6:0]           st;
  logic [31:0]          t;

  assign off  = word_i.off_time;
  assign conf = word_i.confirm_time;
  assign dis  = word_i.disable_time;
  assign en   = word_i.enable_time;

  assign c_ge_o = conf >= off;
  assign d_ge_o = dis >= off;
  assign e_ge_o = en >= off;
  assign o_ge_d = off >= dis;
  assign c_ge_d = conf >= dis;
  assign d_ge_c = dis >= conf;
  assign e_ge_c = en >= conf;
  assign d_ge_e = dis >= en;
  assign e_ge_d = en >= dis;

  always_comb begin
    for (int k = 0; k < NumEvents; k++) begin
      pend[k] = word_i.send_flags[k] & word_i.send_mask[word_i.pc_index]
              & ~word_i.sent_masks[k][word_i.pc_index];
    end
  end

  assign set = {pend[FlEnable], pend[FlDisable], pend[FlConfirm], pend[FlNegate]};

  // decision tree over pending events
  always_comb begin
    if (pend[FlAssert]) begin
      kind = EV_ASSERT;
    end else begin
      case (set)
        4'd1:  kind = EV_NEGATE;
        4'd2:  kind = EV_CONFIRM;
        4'd3:  kind = c_ge_o ? EV_NEGATE : EV_CONFIRM;
        4'd4:  kind = EV_DISABLE;
        4'd5:  kind = d_ge_o ? EV_NEGATE : EV_DISABLE;
        4'd6:  kind = o_ge_d ? EV_DISABLE : EV_CONFIRM;
        4'd7: begin
          if (d_ge_o) kind = c_ge_o ? EV_NEGATE : EV_CONFIRM;
          else        kind = c_ge_d ? EV_DISABLE : EV_CONFIRM;
        end
        4'd8:  kind = EV_ENABLE;
        4'd9:  kind = e_ge_o ? EV_NEGATE : EV_ENABLE;
        4'd10: kind = e_ge_c ? EV_CONFIRM : EV_ENABLE;
        4'd11: begin
          if (e_ge_o) kind = c_ge_o ? EV_NEGATE : EV_CONFIRM;
          else        kind = (conf >= en) ? EV_ENABLE : EV_CONFIRM;
        end
        4'd12: kind = e_ge_d ? EV_DISABLE : EV_ENABLE;
        4'd13: begin
          if (e_ge_o) kind = d_ge_o ? EV_NEGATE : EV_DISABLE;
          else        kind = d_ge_e ? EV_ENABLE : EV_DISABLE;
        end
        4'd14: begin
          if (e_ge_c) kind = d_ge_c ? EV_CONFIRM : EV_DISABLE;
          else        kind = d_ge_e ? EV_ENABLE : EV_DISABLE;
        end
        4'd15: begin
          if (d_ge_o) begin
            if (c_ge_o) kind = e_ge_o ? EV_NEGATE : EV_ENABLE;
            else        kind = e_ge_c ? EV_CONFIRM : EV_ENABLE;
          end else begin
            if (c_ge_d) kind = e_ge_d ? EV_DISABLE : EV_ENABLE;
            else        kind = e_ge_c ? EV_CONFIRM : EV_ENABLE;
          end
        end
        default: kind = EV_NONE;
      endcase
    end
  end

  // timestamp and status for the chosen event, zero time means unset
  always_comb begin
    t  = '0;
    st = '0;
    unique case (kind)
      EV_ASSERT: begin
        t  = word_i.init_time;
        st[StActive] = 1'b1;
        st[StClassLsb +: 4] = word_i.alarm_class;
      end
      EV_NEGATE: begin
        t  = off;
        st[StClassLsb +: 4] = word_i.alarm_class;
        st[StConfirmed] = (conf != '0) && !c_ge_o;
        st[StDisabled]  = (dis != '0) && !d_ge_o && !((en != '0) && !e_ge_o);
      end
      EV_CONFIRM: begin
        t  = conf;
        st[StClassLsb +: 4] = word_i.alarm_class;
        st[StConfirmed] = 1'b1;
        st[StActive]    = !((off != '0) && c_ge_o);
        st[StDisabled]  = (dis != '0) && !d_ge_c;
      end
      EV_DISABLE: begin
        t  = dis;
        st[StClassLsb +: 4] = word_i.alarm_class;
        st[StDisabled]  = 1'b1;
        st[StActive]    = !((off != '0) && d_ge_o);
        st[StConfirmed] = (conf != '0) && d_ge_c;
      end
      EV_ENABLE: begin
        t  = en;
        st[StClassLsb +: 4] = word_i.alarm_class;
        st[StActive]    = !((off != '0) && e_ge_o);
        st[StConfirmed] = (conf != '0) && e_ge_c;
      end
      default: begin
        t  = '0;
        st = '0;
      end
    endcase
  end

  assign res_o.event_kind  = kind;
  assign res_o.event_time  = t;
  assign res_o.status_word = st;

endmodule

// ===== src/alarm_event_selector_top.sv =====
// Alarm event selector: for one alarm entry and one receiver index it returns the next
// event still owed to that receiver, its timestamp and a status word. A word is taken
// on every clock edge where start_i is high; busy_o stays low, so a new word may
// follow in every cycle. Each word gives exactly one result, shown on res_o for one
// cycle with done_o high. The path is an input register, the event decision with its
// 32-bit timestamp compares, and a result register. The receiver cannot stall and
// must take the result in the cycle it is shown.
module alarm_event_selector_top import aes_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  aes_in_t  in_word_i,
  output logic     done_o,
  output aes_out_t res_o
);

  aes_in_t  in_q;
  logic     in_vld_q;
  aes_out_t res_d, res_q;
  logic     done_q;
  logic     accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= accept;
      done_q   <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  aes_decide u_decide (
    .word_i (in_q),
    .res_o  (res_d)
  );

  assign done_o = done_q;
  assign res_o  = res_q;

  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("accepted word gave no result");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.event_kind <= EV_ENABLE)
    else $error("event kind out of range");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.event_kind == EV_NONE |->
      res_o.event_time == '0 && res_o.status_word == '0)
    else $error("empty result not cleared");

  a_assert_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.event_kind == EV_ASSERT |-> res_o.status_word[StActive])
    else $error("assert event without active bit");

  a_confirm_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.event_kind == EV_CONFIRM |-> res_o.status_word[StConfirmed])
    else $error("confirm event without confirmed bit");

endmodule
